// ===== hw/rtl/tes_pkg.sv =====
// Shared types, codes and constants of the timed event scheduler.
`default_nettype none

package tes_pkg;

  // Field widths fixed by the interface.
  localparam int CfgWidth    = 24;
  localparam int NumCfg      = 6;
  localparam int CfgIdxWidth = 3;
  localparam int KindWidth   = 4;
  localparam int IndexWidth  = 2;
  localparam int OrderWidth  = 16;
  localparam int StatusWidth = 2;
  localparam int DelayWidth  = 24;
  localparam int StartWidth  = 24;

  // A tick reports at most this many events.
  localparam int MaxResults = 16;

  // Number of periodic events loaded at reset.
  localparam int StartCount = 8;
  localparam int StartIdxWidth = 3;

  // Result status codes.
  localparam logic [StatusWidth-1:0] STATUS_FIRED   = 2'd0;
  localparam logic [StatusWidth-1:0] STATUS_SCHED   = 2'd1;
  localparam logic [StatusWidth-1:0] STATUS_DROPPED = 2'd2;

  // Event kind codes.
  localparam logic [KindWidth-1:0] KIND_NONE     = 4'd0;
  localparam logic [KindWidth-1:0] KIND_DMA      = 4'd1;
  localparam logic [KindWidth-1:0] KIND_TIMER    = 4'd2;
  localparam logic [KindWidth-1:0] KIND_TONE     = 4'd3;
  localparam logic [KindWidth-1:0] KIND_LENGTH   = 4'd4;
  localparam logic [KindWidth-1:0] KIND_SWEEP    = 4'd5;
  localparam logic [KindWidth-1:0] KIND_ENVELOPE = 4'd6;
  localparam logic [KindWidth-1:0] KIND_DRAW     = 4'd7;
  localparam logic [KindWidth-1:0] KIND_HBLANK   = 4'd8;
  localparam logic [KindWidth-1:0] KIND_VBLANK   = 4'd9;
  localparam logic [KindWidth-1:0] KIND_LINE_INC = 4'd10;

  // Configuration register indexes.
  localparam logic [CfgIdxWidth-1:0] CFG_PSG_PERIOD      = 3'd0;
  localparam logic [CfgIdxWidth-1:0] CFG_LENGTH_PERIOD   = 3'd1;
  localparam logic [CfgIdxWidth-1:0] CFG_SWEEP_PERIOD    = 3'd2;
  localparam logic [CfgIdxWidth-1:0] CFG_ENVELOPE_PERIOD = 3'd3;
  localparam logic [CfgIdxWidth-1:0] CFG_LINE_PERIOD     = 3'd4;
  localparam logic [CfgIdxWidth-1:0] CFG_FRAME_PERIOD    = 3'd5;

  typedef logic [NumCfg-1:0][CfgWidth-1:0] cfg_array_t;

  // Register reset values, index 0 on the right.
  localparam cfg_array_t CfgReset = {
    24'd280896, 24'd1232, 24'd262144, 24'd131072, 24'd65536, 24'd4
  };

  // Kinds and due times of the events present after reset, slot 0 on the right.
  localparam logic [StartCount-1:0][KindWidth-1:0] StartKind = {
    KIND_VBLANK, KIND_LINE_INC, KIND_HBLANK, KIND_DRAW,
    KIND_ENVELOPE, KIND_SWEEP, KIND_LENGTH, KIND_TONE
  };
  localparam logic [StartCount-1:0][StartWidth-1:0] StartDue = {
    24'd197120, 24'd1232, 24'd1006, 24'd1,
    24'd262144, 24'd131072, 24'd65536, 24'd4
  };

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCHED,
    S_SCAN,
    S_LAST,
    S_FIRE,
    S_DONE
  } tes_state_t;

  // Re-insertion period of a kind; zero for kinds that are removed when fired.
  // A period register written as zero acts as a period of one.
  function automatic logic [CfgWidth-1:0] period_of(input logic [KindWidth-1:0] kind,
                                                     input cfg_array_t cfg);
    logic [CfgWidth-1:0] p;
    logic periodic;
    p = '0;
    periodic = 1'b1;
    case (kind) inside
      KIND_TONE:                             p = cfg[CFG_PSG_PERIOD];
      KIND_LENGTH:                           p = cfg[CFG_LENGTH_PERIOD];
      KIND_SWEEP:                            p = cfg[CFG_SWEEP_PERIOD];
      KIND_ENVELOPE:                         p = cfg[CFG_ENVELOPE_PERIOD];
      KIND_DRAW, KIND_HBLANK, KIND_LINE_INC: p = cfg[CFG_LINE_PERIOD];
      KIND_VBLANK:                           p = cfg[CFG_FRAME_PERIOD];
      default:                               periodic = 1'b0;
    endcase
    if (periodic && (p == '0)) begin
      p = CfgWidth'(1);
    end
    return p;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/tes_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module tes_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/timed_event_scheduler.sv =====
// Top level of the timed event scheduler: event store, search sequencer and result port.
`default_nettype none

// A schedule command (in_mode = 1) takes the lowest free slot, or is dropped when none is
// free, and gives one result, registered out of S_SCHED; busy is high for one cycle. A tick
// command (in_mode = 0) searches the store for the earliest due event, once per fired event
// plus one final search. Each search reads the store through its single RAM read port, one
// slot per cycle, into one shared compare unit; a tick skips its final search when a cap
// ends it (16 results or QUEUE_DEPTH events handled). Results leave with out_strobe for one
// cycle each and cannot be held off; out_last marks the final result of a command, and a
// tick that fires nothing gives no result. Slots loaded at reset read from constants until
// first rewritten, so no clearing pass follows reset.
module timed_event_scheduler #(
  parameter int QUEUE_DEPTH = 16,
  parameter int TIME_WIDTH  = 64
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // Command channel.
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic                              in_mode,
  input  wire logic [tes_pkg::DelayWidth-1:0]    in_delay,
  input  wire logic [tes_pkg::KindWidth-1:0]     in_event_kind,
  input  wire logic [tes_pkg::IndexWidth-1:0]    in_unit_index,
  // Result channel.
  output logic                                   out_strobe,
  output logic      [tes_pkg::StatusWidth-1:0]   out_status,
  output logic      [tes_pkg::KindWidth-1:0]     out_fired_kind,
  output logic      [tes_pkg::IndexWidth-1:0]    out_fired_index,
  output logic      [TIME_WIDTH-1:0]             out_fire_time,
  output logic                                   out_last,
  // Configuration write port.
  input  wire logic                              cfg_we,
  input  wire logic [tes_pkg::CfgIdxWidth-1:0]   cfg_index,
  input  wire logic [tes_pkg::CfgWidth-1:0]      cfg_wdata
);

  import tes_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int IW = $clog2(QUEUE_DEPTH + 1);
  localparam int RW = $clog2(MaxResults + 1);
  localparam int EW = TIME_WIDTH + KindWidth + IndexWidth + OrderWidth;
  localparam logic [QUEUE_DEPTH-1:0] ValidInit =
    {{(QUEUE_DEPTH - StartCount){1'b0}}, {StartCount{1'b1}}};

  // Control state.
  tes_state_t state_r, state_nxt;
  cfg_array_t cfg_r;
  logic [TIME_WIDTH-1:0]  now_r, now_nxt;
  logic [QUEUE_DEPTH-1:0] valid_r, valid_nxt;
  logic [QUEUE_DEPTH-1:0] written_r, written_nxt;
  logic [OrderWidth-1:0]  ins_cnt_r, ins_cnt_nxt;
  logic [AW-1:0]          scan_r, scan_nxt;
  logic                   cmp_en_r, cmp_en_nxt;
  logic                   best_found_r, best_found_nxt;
  logic [IW-1:0]          iter_r, iter_nxt;
  logic [RW-1:0]          res_r, res_nxt;
  logic                   pend_valid_r, pend_valid_nxt;
  logic                   strobe_r, strobe_nxt;

  // Payload state.
  logic [DelayWidth-1:0]  cmd_delay_r;
  logic [KindWidth-1:0]   cmd_kind_r;
  logic [IndexWidth-1:0]  cmd_index_r;
  logic [AW-1:0]          addr_q_r;
  logic [AW-1:0]          best_addr_r, best_addr_nxt;
  logic [TIME_WIDTH-1:0]  best_due_r, best_due_nxt;
  logic [KindWidth-1:0]   best_kind_r, best_kind_nxt;
  logic [IndexWidth-1:0]  best_index_r, best_index_nxt;
  logic [OrderWidth-1:0]  best_order_r, best_order_nxt;
  logic [KindWidth-1:0]   pend_kind_r, pend_kind_nxt;
  logic [IndexWidth-1:0]  pend_index_r, pend_index_nxt;
  logic [StatusWidth-1:0] status_r, status_nxt;
  logic [KindWidth-1:0]   kind_r, kind_nxt;
  logic [IndexWidth-1:0]  index_r, index_nxt;
  logic [TIME_WIDTH-1:0]  time_r, time_nxt;
  logic                   last_r, last_nxt;

  // Store port.
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [EW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [EW-1:0] ram_rdata;

  // Candidate slot as read back, and fire-stage decode.
  logic [TIME_WIDTH-1:0] cand_due;
  logic [KindWidth-1:0]  cand_kind;
  logic [IndexWidth-1:0] cand_index;
  logic [OrderWidth-1:0] cand_order;
  logic                  cand_take;
  logic [CfgWidth-1:0]   fire_period;
  logic                  fire_reported;
  logic [IW-1:0]         iter_inc;
  logic [RW-1:0]         res_inc;
  logic                  fire_stop;
  logic [AW-1:0]         free_idx;
  logic                  free_found;
  logic                  accept;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  tes_ram #(
    .WIDTH(EW),
    .DEPTH(QUEUE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Slots never rewritten since reset read as their reset contents.
  always_comb begin
    if (written_r[addr_q_r]) begin
      {cand_due, cand_kind, cand_index, cand_order} = ram_rdata;
    end else begin
      cand_due   = TIME_WIDTH'(StartDue[addr_q_r[StartIdxWidth-1:0]]);
      cand_kind  = StartKind[addr_q_r[StartIdxWidth-1:0]];
      cand_index = '0;
      cand_order = OrderWidth'(addr_q_r[StartIdxWidth-1:0]);
    end
  end

  // Shared compare unit: is the candidate valid, due and earlier than the best so far (a tie goes to the lower order)?
  assign cand_take = valid_r[addr_q_r] && (cand_due <= now_r) &&
                     (!best_found_r || (cand_due < best_due_r) ||
                      ((cand_due == best_due_r) && (cand_order < best_order_r)));

  // Lowest free slot for a schedule command.
  always_comb begin
    free_idx   = '0;
    free_found = 1'b0;
    for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_idx   = AW'(i);
        free_found = 1'b1;
      end
    end
  end

  // Fire-stage decode of the chosen event.
  assign fire_period   = period_of(best_kind_r, cfg_r);
  assign fire_reported = (best_kind_r != KIND_NONE);
  assign iter_inc      = iter_r + IW'(1);
  assign res_inc       = res_r + RW'(fire_reported);
  assign fire_stop     = (iter_inc == IW'(QUEUE_DEPTH)) || (res_inc == RW'(MaxResults));

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = in_mode ? S_SCHED : S_SCAN;
        end
      end
      S_SCHED: state_nxt = S_IDLE;
      S_SCAN: begin
        if (scan_r == AW'(QUEUE_DEPTH - 1)) begin
          state_nxt = S_LAST;
        end
      end
      S_LAST: state_nxt = S_FIRE;
      S_FIRE: begin
        if (!best_found_r || fire_stop) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath and store control for each state.
  always_comb begin
    now_nxt        = now_r;
    valid_nxt      = valid_r;
    written_nxt    = written_r;
    ins_cnt_nxt    = ins_cnt_r;
    scan_nxt       = scan_r;
    cmp_en_nxt     = 1'b0;
    best_found_nxt = best_found_r;
    best_addr_nxt  = best_addr_r;
    best_due_nxt   = best_due_r;
    best_kind_nxt  = best_kind_r;
    best_index_nxt = best_index_r;
    best_order_nxt = best_order_r;
    iter_nxt       = iter_r;
    res_nxt        = res_r;
    pend_valid_nxt = pend_valid_r;
    pend_kind_nxt  = pend_kind_r;
    pend_index_nxt = pend_index_r;
    strobe_nxt     = 1'b0;
    status_nxt     = status_r;
    kind_nxt       = kind_r;
    index_nxt      = index_r;
    time_nxt       = time_r;
    last_nxt       = last_r;
    ram_we         = 1'b0;
    ram_waddr      = best_addr_r;
    ram_wdata      = {TIME_WIDTH'(now_r + TIME_WIDTH'(fire_period)),
                      best_kind_r, best_index_r, ins_cnt_r};
    ram_raddr      = scan_r;

    unique case (state_r)
      S_IDLE: begin
        // A tick starts its first search with clean counters.
        scan_nxt       = '0;
        best_found_nxt = 1'b0;
        iter_nxt       = '0;
        res_nxt        = '0;
      end

      S_SCHED: begin
        strobe_nxt = 1'b1;
        kind_nxt   = cmd_kind_r;
        index_nxt  = cmd_index_r;
        time_nxt   = now_r;
        last_nxt   = 1'b1;
        if (free_found) begin
          status_nxt            = STATUS_SCHED;
          ram_we                = 1'b1;
          ram_waddr             = free_idx;
          ram_wdata             = {TIME_WIDTH'(now_r + TIME_WIDTH'(cmd_delay_r)),
                                   cmd_kind_r, cmd_index_r, ins_cnt_r};
          valid_nxt[free_idx]   = 1'b1;
          written_nxt[free_idx] = 1'b1;
          ins_cnt_nxt           = ins_cnt_r + OrderWidth'(1);
        end else begin
          status_nxt = STATUS_DROPPED;
        end
      end

      S_SCAN, S_LAST: begin
        // Issue one slot read per cycle; compare the slot read in the cycle before.
        if (state_r == S_SCAN) begin
          cmp_en_nxt = 1'b1;
          scan_nxt   = scan_r + AW'(1);
        end
        if (cmp_en_r && cand_take) begin
          best_found_nxt = 1'b1;
          best_addr_nxt  = addr_q_r;
          best_due_nxt   = cand_due;
          best_kind_nxt  = cand_kind;
          best_index_nxt = cand_index;
          best_order_nxt = cand_order;
        end
      end

      S_FIRE: begin
        scan_nxt       = '0;
        best_found_nxt = 1'b0;
        if (best_found_r) begin
          iter_nxt = iter_inc;
          res_nxt  = res_inc;
          // A reported event waits one step so that the final one can carry last.
          if (fire_reported) begin
            if (pend_valid_r) begin
              strobe_nxt = 1'b1;
              status_nxt = STATUS_FIRED;
              kind_nxt   = pend_kind_r;
              index_nxt  = pend_index_r;
              time_nxt   = now_r;
              last_nxt   = 1'b0;
            end
            pend_valid_nxt = 1'b1;
            pend_kind_nxt  = best_kind_r;
            pend_index_nxt = best_index_r;
          end
          // Periodic kinds go back in one period later; others leave the store.
          if (fire_period != '0) begin
            ram_we                   = 1'b1;
            written_nxt[best_addr_r] = 1'b1;
            ins_cnt_nxt              = ins_cnt_r + OrderWidth'(1);
          end else begin
            valid_nxt[best_addr_r] = 1'b0;
          end
        end
      end

      S_DONE: begin
        if (pend_valid_r) begin
          strobe_nxt     = 1'b1;
          status_nxt     = STATUS_FIRED;
          kind_nxt       = pend_kind_r;
          index_nxt      = pend_index_r;
          time_nxt       = now_r;
          last_nxt       = 1'b1;
          pend_valid_nxt = 1'b0;
        end
        now_nxt = now_r + TIME_WIDTH'(1);
      end

      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cfg_r        <= CfgReset;
      now_r        <= '0;
      valid_r      <= ValidInit;
      written_r    <= '0;
      ins_cnt_r    <= OrderWidth'(StartCount);
      scan_r       <= '0;
      cmp_en_r     <= 1'b0;
      best_found_r <= 1'b0;
      iter_r       <= '0;
      res_r        <= '0;
      pend_valid_r <= 1'b0;
      strobe_r     <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      now_r        <= now_nxt;
      valid_r      <= valid_nxt;
      written_r    <= written_nxt;
      ins_cnt_r    <= ins_cnt_nxt;
      scan_r       <= scan_nxt;
      cmp_en_r     <= cmp_en_nxt;
      best_found_r <= best_found_nxt;
      iter_r       <= iter_nxt;
      res_r        <= res_nxt;
      pend_valid_r <= pend_valid_nxt;
      strobe_r     <= strobe_nxt;
      if (cfg_we && (cfg_index < CfgIdxWidth'(NumCfg))) begin
        cfg_r[cfg_index] <= cfg_wdata;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_delay_r <= in_delay;
      cmd_kind_r  <= in_event_kind;
      cmd_index_r <= in_unit_index;
    end
    addr_q_r     <= scan_r;
    best_addr_r  <= best_addr_nxt;
    best_due_r   <= best_due_nxt;
    best_kind_r  <= best_kind_nxt;
    best_index_r <= best_index_nxt;
    best_order_r <= best_order_nxt;
    pend_kind_r  <= pend_kind_nxt;
    pend_index_r <= pend_index_nxt;
    status_r     <= status_nxt;
    kind_r       <= kind_nxt;
    index_r      <= index_nxt;
    time_r       <= time_nxt;
    last_r       <= last_nxt;
  end

  assign out_strobe      = strobe_r;
  assign out_status      = status_r;
  assign out_fired_kind  = kind_r;
  assign out_fired_index = index_r;
  assign out_fire_time   = time_r;
  assign out_last        = last_r;

endmodule

`default_nettype wire
